### src/bgd_pkg.sv
// Shared types, codes and lookup functions for the button gesture decoder.
// No dependencies; imported by bgd_step and button_gesture_decoder_core.
package bgd_pkg;

    localparam logic [9:0] CODE_VOLDOWN = 10'd114;
    localparam logic [9:0] CODE_VOLUP   = 10'd115;
    localparam logic [9:0] CODE_POWER   = 10'd116;

    localparam logic [4:0] EV_KEY      = 5'd1;
    localparam logic [1:0] KV_RELEASE  = 2'd0;
    localparam logic [1:0] KV_PRESS    = 2'd1;
    localparam logic [1:0] KV_REPEAT   = 2'd2;
    localparam logic       OP_KEY      = 1'b0;
    localparam logic       OP_TICK     = 1'b1;

    localparam logic [2:0] MASK_VOLUP   = 3'b001;
    localparam logic [2:0] MASK_VOLDOWN = 3'b010;
    localparam logic [2:0] MASK_POWER   = 3'b100;

    localparam logic [3:0] GID_NONE        = 4'd0;
    localparam logic [3:0] GID_CLICK       = 4'd1;
    localparam logic [3:0] GID_DOUBLE      = 4'd4;
    localparam logic [3:0] GID_LONG        = 4'd7;
    localparam logic [3:0] GID_UP_DOWN     = 4'd10;
    localparam logic [3:0] GID_UP_POWER    = 4'd11;
    localparam logic [3:0] GID_DOWN_POWER  = 4'd12;
    localparam logic [3:0] GID_ALL         = 4'd13;

    localparam logic [3:0] MA_NONE     = 4'd0;
    localparam logic [3:0] MA_PREV     = 4'd1;
    localparam logic [3:0] MA_NEXT     = 4'd2;
    localparam logic [3:0] MA_SELECT   = 4'd3;
    localparam logic [3:0] MA_BACK     = 4'd4;
    localparam logic [3:0] MA_HIDE     = 4'd5;
    localparam logic [3:0] MA_PGPREV   = 4'd6;
    localparam logic [3:0] MA_PGNEXT   = 4'd7;
    localparam logic [3:0] MA_STATUS   = 4'd8;
    localparam logic [3:0] MA_LOG      = 4'd9;
    localparam logic [3:0] MA_RESERVED = 4'd10;

    localparam logic [1:0] CLICKS_ONE = 2'd1;
    localparam logic [1:0] CLICKS_TWO = 2'd2;

    localparam logic       CFG_DOUBLE_CLICK = 1'b0;
    localparam logic       CFG_LONG_PRESS   = 1'b1;
    localparam logic [15:0] DOUBLE_CLICK_RST = 16'd400;
    localparam logic [15:0] LONG_PRESS_RST   = 16'd800;

    typedef struct packed {
        logic        op;
        logic [4:0]  event_type;
        logic [9:0]  key_code;
        logic [1:0]  key_value;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic        pending_flag;
        logic        second_click_flag;
        logic [2:0]  held_mask;
        logic [2:0]  seen_mask;
        logic [9:0]  first_key;
        logic [2:0]  first_mask;
        logic [31:0] press_time;
        logic [9:0]  pending_key;
        logic [2:0]  pending_bits;
        logic [31:0] release_time;
        logic [31:0] pending_length;
    } state_t;

    typedef struct packed {
        logic        gesture_valid;
        logic [3:0]  gesture_id;
        logic [3:0]  menu_action;
        logic [9:0]  gesture_key;
        logic [2:0]  button_mask;
        logic [1:0]  click_count;
        logic [31:0] press_duration;
        logic        click_parked;
        logic [15:0] wait_left_ms;
    } result_t;

    function automatic logic [2:0] mask_of_key(input logic [9:0] code);
        case (code)
            CODE_VOLUP:   mask_of_key = MASK_VOLUP;
            CODE_VOLDOWN: mask_of_key = MASK_VOLDOWN;
            CODE_POWER:   mask_of_key = MASK_POWER;
            default:      mask_of_key = 3'b000;
        endcase
    endfunction

    // click / double / long id for a single button; long wins over double
    function automatic logic [3:0] single_id(input logic [9:0] code, input logic two,
                                             input logic is_long);
        logic [3:0] k;
        logic       ok;
        begin
            ok = 1'b1;
            case (code)
                CODE_VOLUP:   k = 4'd0;
                CODE_VOLDOWN: k = 4'd1;
                CODE_POWER:   k = 4'd2;
                default: begin
                    k  = 4'd0;
                    ok = 1'b0;
                end
            endcase
            if (!ok)
                single_id = GID_NONE;
            else if (is_long)
                single_id = GID_LONG + k;
            else if (two)
                single_id = GID_DOUBLE + k;
            else
                single_id = GID_CLICK + k;
        end
    endfunction

    function automatic logic [3:0] combo_of_mask(input logic [2:0] m);
        case (m)
            3'b011:  combo_of_mask = GID_UP_DOWN;
            3'b101:  combo_of_mask = GID_UP_POWER;
            3'b110:  combo_of_mask = GID_DOWN_POWER;
            3'b111:  combo_of_mask = GID_ALL;
            default: combo_of_mask = GID_NONE;
        endcase
    endfunction

    function automatic logic [3:0] menu_of_id(input logic [3:0] id);
        case (id)
            4'd1:    menu_of_id = MA_PREV;
            4'd2:    menu_of_id = MA_NEXT;
            4'd3:    menu_of_id = MA_SELECT;
            4'd4:    menu_of_id = MA_PGPREV;
            4'd5:    menu_of_id = MA_PGNEXT;
            4'd6:    menu_of_id = MA_BACK;
            4'd7:    menu_of_id = MA_PGPREV;
            4'd8:    menu_of_id = MA_PGNEXT;
            4'd9:    menu_of_id = MA_RESERVED;
            4'd10:   menu_of_id = MA_BACK;
            4'd11:   menu_of_id = MA_STATUS;
            4'd12:   menu_of_id = MA_LOG;
            4'd13:   menu_of_id = MA_HIDE;
            default: menu_of_id = MA_NONE;
        endcase
    endfunction

endpackage

### src/bgd_step.sv
// Next-state and result logic for one item of the gesture decoder.
// Pure combinational; uses bgd_pkg.
module bgd_step
    import bgd_pkg::*;
(
    input  item_t       item,
    input  state_t      cur,
    input  logic [15:0] double_click_ms,
    input  logic [15:0] long_press_ms,
    output state_t      nxt,
    output result_t     res
);

    logic [2:0]  m;
    logic [31:0] el;
    logic [31:0] dur;
    logic        due;
    logic        pend_long;
    logic        dur_long;
    logic        in_window;
    logic        emit;
    logic        set_pending;
    logic [2:0]  held_after;

    assign m         = mask_of_key(item.key_code);
    assign el        = item.now_ms - cur.release_time;
    assign dur       = item.now_ms - cur.press_time;
    assign due       = el >= {16'd0, double_click_ms};
    assign in_window = el <= {16'd0, double_click_ms};
    assign pend_long = cur.pending_length >= {16'd0, long_press_ms};
    assign dur_long  = dur >= {16'd0, long_press_ms};
    assign held_after = cur.held_mask & ~m;

    always_comb begin
        nxt         = cur;
        res         = '0;
        emit        = 1'b0;
        set_pending = 1'b0;

        if (item.op == OP_TICK) begin
            if (cur.pending_flag && due)
                emit = 1'b1;
        end else if (item.event_type == EV_KEY && m != 3'b000) begin
            if (item.key_value == KV_PRESS) begin
                if (cur.pending_flag) begin
                    if (m == cur.pending_bits && cur.held_mask == 3'b000 && in_window) begin
                        nxt.pending_flag      = 1'b0;
                        nxt.second_click_flag = 1'b1;
                        nxt.held_mask         = m;
                        nxt.seen_mask         = m;
                        nxt.first_key         = item.key_code;
                        nxt.first_mask        = m;
                        nxt.press_time        = item.now_ms;
                    end else begin
                        emit = 1'b1;   // press consumed
                    end
                end else if (cur.held_mask == 3'b000) begin
                    nxt.second_click_flag = 1'b0;
                    nxt.held_mask         = m;
                    nxt.seen_mask         = m;
                    nxt.first_key         = item.key_code;
                    nxt.first_mask        = m;
                    nxt.press_time        = item.now_ms;
                end else begin
                    nxt.held_mask = cur.held_mask | m;
                    nxt.seen_mask = cur.seen_mask | m;
                end
            end else if (item.key_value == KV_RELEASE && (cur.held_mask & m) != 3'b000) begin
                nxt.held_mask = held_after;
                if (held_after == 3'b000) begin
                    if ((cur.seen_mask & (cur.seen_mask - 3'd1)) != 3'b000) begin
                        res.gesture_valid  = 1'b1;
                        res.gesture_id     = combo_of_mask(cur.seen_mask);
                        res.gesture_key    = cur.first_key;
                        res.button_mask    = cur.seen_mask;
                        res.click_count    = CLICKS_ONE;
                        res.press_duration = dur;
                        nxt.seen_mask      = 3'b000;
                    end else if (cur.second_click_flag) begin
                        res.gesture_valid     = 1'b1;
                        res.gesture_id        = single_id(cur.first_key, 1'b1, dur_long);
                        res.gesture_key       = cur.first_key;
                        res.button_mask       = cur.first_mask;
                        res.click_count       = CLICKS_TWO;
                        res.press_duration    = dur;
                        nxt.seen_mask         = 3'b000;
                        nxt.second_click_flag = 1'b0;
                    end else if (dur_long) begin
                        res.gesture_valid  = 1'b1;
                        res.gesture_id     = single_id(cur.first_key, 1'b0, 1'b1);
                        res.gesture_key    = cur.first_key;
                        res.button_mask    = cur.first_mask;
                        res.click_count    = CLICKS_ONE;
                        res.press_duration = dur;
                        nxt.seen_mask      = 3'b000;
                    end else begin
                        set_pending        = 1'b1;
                        nxt.pending_flag   = 1'b1;
                        nxt.pending_key    = cur.first_key;
                        nxt.pending_bits   = cur.first_mask;
                        nxt.release_time   = item.now_ms;
                        nxt.pending_length = dur;
                    end
                end
            end
        end

        if (emit) begin
            res.gesture_valid  = 1'b1;
            res.gesture_id     = single_id(cur.pending_key, 1'b0, pend_long);
            res.gesture_key    = cur.pending_key;
            res.button_mask    = cur.pending_bits;
            res.click_count    = CLICKS_ONE;
            res.press_duration = cur.pending_length;
            nxt.pending_flag   = 1'b0;
        end

        res.menu_action  = menu_of_id(res.gesture_id);
        res.click_parked = nxt.pending_flag;
        // a fresh park starts at now, so the full window is left
        if (set_pending)
            res.wait_left_ms = double_click_ms;
        else if (nxt.pending_flag && !due)
            res.wait_left_ms = double_click_ms - el[15:0];
        else
            res.wait_left_ms = 16'd0;
    end

endmodule

### src/button_gesture_decoder_core.sv
// Pipeline: accepted items enter the input register and are decoded into the result register.
// Throughput: one item per cycle unless m_ready stalls the output; the decode state is updated
// in the same cycle the result register loads, so back-to-back items see each other's effects.
// Reset (aresetn low, synchronous): decode state cleared, double_click_ms = 400,
// long_press_ms = 800, both pipeline stages empty. Config writes always accepted.
module button_gesture_decoder_core
    import bgd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [4:0]  s_event_type,
    input  logic [9:0]  s_key_code,
    input  logic [1:0]  s_key_value,
    input  logic [31:0] s_now_ms,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_gesture_valid,
    output logic [3:0]  m_gesture_id,
    output logic [3:0]  m_menu_action,
    output logic [9:0]  m_gesture_key,
    output logic [2:0]  m_button_mask,
    output logic [1:0]  m_click_count,
    output logic [31:0] m_press_duration,
    output logic        m_click_parked,
    output logic [15:0] m_wait_left_ms
);

    logic [15:0] double_click_reg;
    logic [15:0] long_press_reg;
    item_t       item_reg;
    logic        item_valid_reg;
    state_t      state_reg;
    state_t      state_next;
    result_t     result_reg;
    result_t     result_next;
    logic        out_valid_reg;
    logic        advance;

    assign cfg_ready = 1'b1;
    assign advance   = item_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !item_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            double_click_reg <= DOUBLE_CLICK_RST;
            long_press_reg   <= LONG_PRESS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DOUBLE_CLICK: double_click_reg <= cfg_data;
                CFG_LONG_PRESS:   long_press_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_ready) begin
            item_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            item_reg.op         <= s_op;
            item_reg.event_type <= s_event_type;
            item_reg.key_code   <= s_key_code;
            item_reg.key_value  <= s_key_value;
            item_reg.now_ms     <= s_now_ms;
        end
    end

    bgd_step u_step (
        .item            (item_reg),
        .cur             (state_reg),
        .double_click_ms (double_click_reg),
        .long_press_ms   (long_press_reg),
        .nxt             (state_next),
        .res             (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance)
                state_reg <= state_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_ready)
                out_valid_reg <= 1'b0;
        end
        if (advance)
            result_reg <= result_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_gesture_valid  = result_reg.gesture_valid;
    assign m_gesture_id     = result_reg.gesture_id;
    assign m_menu_action    = result_reg.menu_action;
    assign m_gesture_key    = result_reg.gesture_key;
    assign m_button_mask    = result_reg.button_mask;
    assign m_click_count    = result_reg.click_count;
    assign m_press_duration = result_reg.press_duration;
    assign m_click_parked   = result_reg.click_parked;
    assign m_wait_left_ms   = result_reg.wait_left_ms;

    // a parked click only exists with all buttons up
    a_pending_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.pending_flag |-> state_reg.held_mask == 3'b000)
        else $error("click parked while a button is held");

    a_held_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.held_mask & ~state_reg.seen_mask) == 3'b000)
        else $error("held button missing from seen mask");

    a_no_gesture_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !result_reg.gesture_valid |->
            result_reg.gesture_id == GID_NONE && result_reg.click_count == 2'd0 &&
            result_reg.press_duration == 32'd0)
        else $error("result fields set without a gesture");

    a_wait_only_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !result_reg.click_parked |-> result_reg.wait_left_ms == 16'd0)
        else $error("wait left reported with nothing pending");

    a_clicks: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && result_reg.gesture_valid |->
            result_reg.click_count == CLICKS_ONE || result_reg.click_count == CLICKS_TWO)
        else $error("gesture with bad click count");

endmodule

### dv/button_gesture_decoder_core_tb.sv
// Self-checking testbench for button_gesture_decoder_core: directed gestures, then random
// gesture streams under several register settings, with random idling on both channels.
// Depends on bgd_pkg (codes, item and result types) and the core RTL.
module button_gesture_decoder_core_tb;
    import bgd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] MENU_BY_ID [16] = '{
        MA_NONE, MA_PREV, MA_NEXT, MA_SELECT, MA_PGPREV, MA_PGNEXT, MA_BACK, MA_PGPREV,
        MA_PGNEXT, MA_RESERVED, MA_BACK, MA_STATUS, MA_LOG, MA_HIDE, MA_NONE, MA_NONE
    };
    localparam int SETTLE_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op = 1'b0;
    logic [4:0]  s_event_type = '0;
    logic [9:0]  s_key_code = '0;
    logic [1:0]  s_key_value = '0;
    logic [31:0] s_now_ms = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_gesture_valid;
    logic [3:0]  m_gesture_id;
    logic [3:0]  m_menu_action;
    logic [9:0]  m_gesture_key;
    logic [2:0]  m_button_mask;
    logic [1:0]  m_click_count;
    logic [31:0] m_press_duration;
    logic        m_click_parked;
    logic [15:0] m_wait_left_ms;

    button_gesture_decoder_core u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_event_type     (s_event_type),
        .s_key_code       (s_key_code),
        .s_key_value      (s_key_value),
        .s_now_ms         (s_now_ms),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_gesture_valid  (m_gesture_valid),
        .m_gesture_id     (m_gesture_id),
        .m_menu_action    (m_menu_action),
        .m_gesture_key    (m_gesture_key),
        .m_button_mask    (m_button_mask),
        .m_click_count    (m_click_count),
        .m_press_duration (m_press_duration),
        .m_click_parked   (m_click_parked),
        .m_wait_left_ms   (m_wait_left_ms)
    );

    always #5 aclk = ~aclk;

    // decoder shadow: register copies and gesture state
    logic [15:0] dbl_ms = DOUBLE_CLICK_RST;
    logic [15:0] long_ms = LONG_PRESS_RST;
    state_t      gst = '0;

    item_t       queued_inputs[$];
    result_t     gesture_reports[$];
    item_t       drv_item;
    int unsigned n_queued = 0;
    int unsigned n_live = 0;
    int unsigned n_accepted = 0;
    int unsigned n_errors = 0;
    int          send_gap = 0;
    int          hold_cnt = 0;
    logic        steady = 1'b0;
    logic [31:0] stamp = '0;

    function automatic logic [2:0] button_bit(input logic [9:0] code);
        if (code == CODE_VOLUP) return MASK_VOLUP;
        if (code == CODE_VOLDOWN) return MASK_VOLDOWN;
        if (code == CODE_POWER) return MASK_POWER;
        return 3'b000;
    endfunction

    function automatic logic [3:0] button_gesture_id(input logic [9:0] code,
                                                     input logic [1:0] clicks,
                                                     input logic [31:0] held_for);
        logic [3:0] k;
        case (code)
            CODE_VOLUP:   k = 4'd0;
            CODE_VOLDOWN: k = 4'd1;
            CODE_POWER:   k = 4'd2;
            default:      return GID_NONE;
        endcase
        if (held_for >= {16'd0, long_ms}) return GID_LONG + k;
        if (clicks == CLICKS_TWO) return GID_DOUBLE + k;
        return GID_CLICK + k;
    endfunction

    function automatic logic [3:0] combo_gesture_id(input logic [2:0] bits);
        case (bits)
            MASK_VOLUP | MASK_VOLDOWN:              return GID_UP_DOWN;
            MASK_VOLUP | MASK_POWER:                return GID_UP_POWER;
            MASK_VOLDOWN | MASK_POWER:              return GID_DOWN_POWER;
            MASK_VOLUP | MASK_VOLDOWN | MASK_POWER: return GID_ALL;
            default:                                return GID_NONE;
        endcase
    endfunction

    function automatic result_t gesture(input logic [3:0] id, input logic [9:0] code,
                                        input logic [2:0] bits, input logic [1:0] clicks,
                                        input logic [31:0] held_for);
        result_t r;
        r = '0;
        r.gesture_valid  = 1'b1;
        r.gesture_id     = id;
        r.menu_action    = MENU_BY_ID[id];
        r.gesture_key    = code;
        r.button_mask    = bits;
        r.click_count    = clicks;
        r.press_duration = held_for;
        return r;
    endfunction

    function automatic result_t flush_parked_click();
        gst.pending_flag = 1'b0;
        return gesture(button_gesture_id(gst.pending_key, CLICKS_ONE, gst.pending_length),
                       gst.pending_key, gst.pending_bits, CLICKS_ONE, gst.pending_length);
    endfunction

    function automatic void start_press(input logic [9:0] code, input logic [2:0] bits,
                                        input logic [31:0] at_ms);
        gst.held_mask  = bits;
        gst.seen_mask  = bits;
        gst.first_key  = code;
        gst.first_mask = bits;
        gst.press_time = at_ms;
    endfunction

    // one report per item; updates the shadow state
    function automatic result_t decode_event(input item_t it);
        result_t     r;
        logic [2:0]  b;
        logic [31:0] since_release;
        logic [31:0] held_for;
        r = '0;
        b = button_bit(it.key_code);
        since_release = it.now_ms - gst.release_time;
        if (it.op == OP_TICK) begin
            if (gst.pending_flag && since_release >= {16'd0, dbl_ms})
                r = flush_parked_click();
        end else if (it.event_type == EV_KEY && b != 3'b000) begin
            if (it.key_value == KV_PRESS) begin
                if (gst.pending_flag) begin
                    if (b == gst.pending_bits && gst.held_mask == 3'b000 &&
                        since_release <= {16'd0, dbl_ms}) begin
                        gst.pending_flag = 1'b0;
                        gst.second_click_flag = 1'b1;
                        start_press(it.key_code, b, it.now_ms);
                    end else begin
                        // parked click goes out, this press is swallowed
                        r = flush_parked_click();
                    end
                end else if (gst.held_mask == 3'b000) begin
                    gst.second_click_flag = 1'b0;
                    start_press(it.key_code, b, it.now_ms);
                end else begin
                    gst.held_mask |= b;
                    gst.seen_mask |= b;
                end
            end else if (it.key_value == KV_RELEASE && (gst.held_mask & b) != 3'b000) begin
                gst.held_mask &= ~b;
                if (gst.held_mask == 3'b000) begin
                    held_for = it.now_ms - gst.press_time;
                    if ($countones(gst.seen_mask) > 1) begin
                        r = gesture(combo_gesture_id(gst.seen_mask), gst.first_key,
                                    gst.seen_mask, CLICKS_ONE, held_for);
                        gst.seen_mask = 3'b000;
                    end else if (gst.second_click_flag) begin
                        r = gesture(button_gesture_id(gst.first_key, CLICKS_TWO, held_for),
                                    gst.first_key, gst.first_mask, CLICKS_TWO, held_for);
                        gst.seen_mask = 3'b000;
                        gst.second_click_flag = 1'b0;
                    end else if (held_for >= {16'd0, long_ms}) begin
                        r = gesture(button_gesture_id(gst.first_key, CLICKS_ONE, held_for),
                                    gst.first_key, gst.first_mask, CLICKS_ONE, held_for);
                        gst.seen_mask = 3'b000;
                    end else begin
                        gst.pending_flag   = 1'b1;
                        gst.pending_key    = gst.first_key;
                        gst.pending_bits   = gst.first_mask;
                        gst.release_time   = it.now_ms;
                        gst.pending_length = held_for;
                    end
                end
            end
        end
        r.click_parked = gst.pending_flag;
        if (gst.pending_flag) begin
            since_release = it.now_ms - gst.release_time;
            if (since_release < {16'd0, dbl_ms})
                r.wait_left_ms = dbl_ms - since_release[15:0];
        end
        return r;
    endfunction

    // input driver
    always @(posedge aclk) begin : drive
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                gesture_reports.push_back(decode_event(drv_item));
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (queued_inputs.size() != 0) begin
                    drv_item = queued_inputs.pop_front();
                    s_op         <= drv_item.op;
                    s_event_type <= drv_item.event_type;
                    s_key_code   <= drv_item.key_code;
                    s_key_value  <= drv_item.key_value;
                    s_now_ms     <= drv_item.now_ms;
                    s_valid      <= 1'b1;
                    if (!steady && $urandom_range(0, 4) == 0)
                        send_gap = $urandom_range(1, 4);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    // result monitor with random back-pressure
    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_cnt = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (gesture_reports.size() == 0) begin
                    $error("result item with no report pending");
                    n_errors++;
                end else begin
                    want = gesture_reports.pop_front();
                    check_field("gesture_valid", 32'(want.gesture_valid),
                                32'(m_gesture_valid));
                    check_field("gesture_id", 32'(want.gesture_id), 32'(m_gesture_id));
                    check_field("menu_action", 32'(want.menu_action), 32'(m_menu_action));
                    check_field("gesture_key", 32'(want.gesture_key), 32'(m_gesture_key));
                    check_field("button_mask", 32'(want.button_mask), 32'(m_button_mask));
                    check_field("click_count", 32'(want.click_count), 32'(m_click_count));
                    check_field("press_duration", want.press_duration, m_press_duration);
                    check_field("click_parked", 32'(want.click_parked), 32'(m_click_parked));
                    check_field("wait_left_ms", 32'(want.wait_left_ms), 32'(m_wait_left_ms));
                end
            end
            if (hold_cnt != 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else if (!steady && $urandom_range(0, 4) == 0) begin
                hold_cnt = $urandom_range(0, 3);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_DOUBLE_CLICK)
            dbl_ms = val;
        else
            long_ms = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [15:0] dbl, input logic [15:0] lng);
        write_reg(CFG_DOUBLE_CLICK, dbl);
        write_reg(CFG_LONG_PRESS, lng);
    endtask

    // wait until every queued item has been answered
    task automatic settle();
        int waited;
        waited = 0;
        while ((n_accepted != n_queued || gesture_reports.size() != 0) &&
               waited < SETTLE_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (n_accepted != n_queued || gesture_reports.size() != 0) begin
            $error("%0d items unaccepted, %0d reports never arrived",
                   n_queued - n_accepted, gesture_reports.size());
            n_errors++;
        end
        repeat (4) @(posedge aclk);
    endtask

    function automatic item_t key_item(input logic [9:0] code, input logic [1:0] value,
                                       input logic [31:0] at_ms);
        item_t it;
        it.op         = OP_KEY;
        it.event_type = EV_KEY;
        it.key_code   = code;
        it.key_value  = value;
        it.now_ms     = at_ms;
        return it;
    endfunction

    task automatic add_raw(input item_t it);
        queued_inputs.push_back(it);
        n_queued++;
    endtask

    task automatic add_key(input logic [9:0] code, input logic [1:0] value,
                           input logic [31:0] at_ms);
        add_raw(key_item(code, value, at_ms));
        n_live++;
    endtask

    // time check; the key fields carry junk, which the block must ignore
    task automatic add_tick(input logic [31:0] at_ms);
        item_t it;
        it.op         = OP_TICK;
        it.event_type = 5'($urandom_range(0, 31));
        it.key_code   = 10'($urandom_range(0, 1023));
        it.key_value  = 2'($urandom_range(0, 3));
        it.now_ms     = at_ms;
        add_raw(it);
        n_live++;
    endtask

    function automatic logic [9:0] random_button();
        case ($urandom_range(0, 2))
            0:       return CODE_VOLUP;
            1:       return CODE_VOLDOWN;
            default: return CODE_POWER;
        endcase
    endfunction

    // a span near a threshold, or anywhere up to twice it plus two
    function automatic logic [31:0] pick_span(input logic [15:0] limit);
        case ($urandom_range(0, 5))
            0:       return {16'd0, limit};
            1:       return {16'd0, limit} + 32'd1;
            2:       return (limit == 16'd0) ? 32'd0 : {16'd0, limit} - 32'd1;
            default: return $urandom_range(0, 2 * int'(limit) + 2);
        endcase
    endfunction

    function automatic logic [15:0] pick_reg(input int lo, input int hi);
        case ($urandom_range(0, 4))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    task automatic add_gesture();
        logic [9:0] k;
        logic [9:0] j;
        logic [9:0] order[$];
        item_t      it;
        int         idx;
        k = random_button();
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                add_key(k, KV_PRESS, stamp);
                stamp += pick_span(long_ms);
                add_key(k, KV_RELEASE, stamp);
                stamp += pick_span(dbl_ms);
                if ($urandom_range(0, 1) == 1)
                    add_tick(stamp);
            end
            3, 4: begin
                repeat (2) begin
                    add_key(k, KV_PRESS, stamp);
                    stamp += pick_span(long_ms);
                    add_key(k, KV_RELEASE, stamp);
                    stamp += pick_span(dbl_ms);
                end
            end
            5, 6: begin
                do j = random_button(); while (j == k);
                order.push_back(k);
                order.push_back(j);
                // the three codes sum to a constant, so this is the remaining button
                if ($urandom_range(0, 2) == 0)
                    order.push_back(CODE_VOLUP + CODE_VOLDOWN + CODE_POWER - k - j);
                foreach (order[i]) begin
                    add_key(order[i], KV_PRESS, stamp);
                    stamp += $urandom_range(0, 60);
                end
                stamp += pick_span(long_ms);
                while (order.size() != 0) begin
                    idx = $urandom_range(0, order.size() - 1);
                    add_key(order[idx], KV_RELEASE, stamp);
                    order.delete(idx);
                    stamp += $urandom_range(0, 60);
                end
                stamp += pick_span(dbl_ms);
            end
            7: begin
                stamp += pick_span(dbl_ms);
                add_tick(stamp);
            end
            8: begin
                it.op         = 1'($urandom_range(0, 1));
                it.event_type = 5'($urandom_range(0, 31));
                it.key_code   = ($urandom_range(0, 1) == 1) ? 10'($urandom_range(0, 1023)) : k;
                it.key_value  = 2'($urandom_range(0, 3));
                it.now_ms     = $urandom();
                add_raw(it);
            end
            default: begin
                // broken sequences: dangling press, autorepeat, stray release
                case ($urandom_range(0, 2))
                    0:       add_key(k, KV_PRESS, stamp);
                    1:       add_raw(key_item(k, KV_REPEAT, stamp));
                    default: add_raw(key_item(k, KV_RELEASE, stamp));
                endcase
                stamp += $urandom_range(0, 100);
            end
        endcase
    endtask

    initial begin : stimulus
        item_t       it;
        int unsigned target;
        logic [15:0] dbl;
        logic [15:0] lng;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ignored events at field extremes
        it.op = OP_KEY;
        it.event_type = 5'd31;
        it.key_code = CODE_VOLUP;
        it.key_value = KV_PRESS;
        it.now_ms = '0;
        add_raw(it);
        add_raw(key_item(10'd1023, 2'd3, 32'hFFFF_FFFF));
        add_key(CODE_VOLUP, KV_REPEAT, 32'd10);
        add_key(CODE_POWER, KV_RELEASE, 32'd20);
        // parked click, time check too early, then the same button after the window
        add_key(CODE_VOLUP, KV_PRESS, 32'd1000);
        add_key(CODE_VOLUP, KV_RELEASE, 32'd1100);
        add_tick(32'd1300);
        add_key(CODE_VOLUP, KV_PRESS, 32'd1600);
        // other button pressed while a click is parked
        add_key(CODE_POWER, KV_PRESS, 32'd2000);
        add_key(CODE_POWER, KV_RELEASE, 32'd2100);
        add_key(CODE_VOLDOWN, KV_PRESS, 32'd2200);
        // plain double click
        add_key(CODE_VOLDOWN, KV_PRESS, 32'd3000);
        add_key(CODE_VOLDOWN, KV_RELEASE, 32'd3050);
        add_key(CODE_VOLDOWN, KV_PRESS, 32'd3300);
        add_key(CODE_VOLDOWN, KV_RELEASE, 32'd3350);
        // double click whose second press is long, across the timestamp wrap
        add_key(CODE_VOLUP, KV_PRESS, 32'hFFFF_FE00);
        add_key(CODE_VOLUP, KV_RELEASE, 32'hFFFF_FE40);
        add_key(CODE_VOLUP, KV_PRESS, 32'hFFFF_FE80);
        add_key(CODE_VOLUP, KV_RELEASE, 32'h0000_0200);
        // combination started on a second click
        add_key(CODE_VOLDOWN, KV_PRESS, 32'd5000);
        add_key(CODE_VOLDOWN, KV_RELEASE, 32'd5050);
        add_key(CODE_VOLDOWN, KV_PRESS, 32'd5100);
        add_key(CODE_VOLUP, KV_PRESS, 32'd5150);
        add_key(CODE_VOLUP, KV_RELEASE, 32'd5200);
        add_key(CODE_VOLDOWN, KV_RELEASE, 32'd5300);
        settle();

        // zero window: parked click is due at once
        set_regs(16'd0, 16'hFFFF);
        add_key(CODE_POWER, KV_PRESS, 32'd6000);
        add_key(CODE_POWER, KV_RELEASE, 32'd6010);
        add_tick(32'd6010);
        add_key(CODE_VOLUP, KV_PRESS, 32'd6100);
        add_key(CODE_VOLUP, KV_RELEASE, 32'd6150);
        settle();
        // long threshold lowered under a parked click
        write_reg(CFG_LONG_PRESS, 16'd5);
        add_key(CODE_VOLDOWN, KV_PRESS, 32'd6200);
        settle();
        // zero long threshold: every single-button release is long
        set_regs(16'hFFFF, 16'd0);
        add_key(CODE_POWER, KV_PRESS, 32'd6300);
        add_key(CODE_POWER, KV_RELEASE, 32'd6300);
        settle();

        for (int phase = 0; phase < 9; phase++) begin
            case (phase)
                1: begin
                    dbl = 16'hFFFF;
                    lng = 16'd1;
                end
                2: begin
                    dbl = 16'd1;
                    lng = 16'hFFFF;
                end
                8: begin
                    dbl = DOUBLE_CLICK_RST;
                    lng = LONG_PRESS_RST;
                    steady = 1'b1;
                end
                default: begin
                    dbl = pick_reg(20, 600);
                    lng = pick_reg(50, 1500);
                end
            endcase
            set_regs(dbl, lng);
            stamp = ($urandom_range(0, 1) == 1) ? $urandom()
                                                 : 32'hFFFF_FFFF - $urandom_range(0, 3000);
            target = n_live + 95;
            while (n_live < target)
                add_gesture();
            settle();
        end

        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
src/bgd_pkg.sv
src/bgd_step.sv
src/button_gesture_decoder_core.sv
dv/button_gesture_decoder_core_tb.sv
